@@ hw/rtl/sofo_pkg.sv @@
// shared types and constants for the square outline and fill overlay
package sofo_pkg;

	localparam int unsigned PIX_W    = 12;
	localparam int unsigned COLOR_W  = 24;
	localparam int unsigned CORNER_W = 14;
	localparam int unsigned THICK_W  = 10;
	localparam int unsigned HALF_W   = 9;
	localparam int unsigned SIDE_W   = 14;
	localparam int unsigned COORD_W  = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned MAX_DIM  = 4096;

	typedef logic signed [COORD_W-1:0] coord_t;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CORNER_A_X    = 3'd0,
		REG_CORNER_A_Y    = 3'd1,
		REG_CORNER_B_X    = 3'd2,
		REG_CORNER_B_Y    = 3'd3,
		REG_BORDER_THICK  = 3'd4,
		REG_BORDER_COLOR  = 3'd5,
		REG_FILL_ENABLE   = 3'd6,
		REG_FILL_COLOR    = 3'd7
	} cfg_reg_t;

	// precomputed square bounds per axis, all inclusive
	typedef struct packed {
		coord_t x_lo;
		coord_t x_hi;
		coord_t x_in;
		coord_t x_out;
		coord_t fx_lo;
		coord_t fx_hi;
		coord_t y_lo;
		coord_t y_hi;
		coord_t y_in;
		coord_t y_out;
		coord_t fy_lo;
		coord_t fy_hi;
		logic   side_en;
		logic   fill_en;
		logic [COLOR_W-1:0] border_color;
		logic [COLOR_W-1:0] fill_color;
	} geom_t;

endpackage

@@ hw/rtl/sofo_cfg.sv @@
// configuration registers and two-stage precompute of the square bounds
module sofo_cfg
	import sofo_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	output geom_t                geom,
	output logic                 geom_ok
);

	logic signed [CORNER_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic [THICK_W-1:0]         thick_q;
	logic [COLOR_W-1:0]         bcolor_q, fcolor_q;
	logic                       fen_q;
	logic [1:0]                 settle_q;
	logic                       cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q     <= '0;
			ay_q     <= '0;
			bx_q     <= '0;
			by_q     <= '0;
			thick_q  <= THICK_W'(1);
			bcolor_q <= '0;
			fen_q    <= 1'b0;
			fcolor_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg_index))
				REG_CORNER_A_X:   ax_q     <= cfg_data[CORNER_W-1:0];
				REG_CORNER_A_Y:   ay_q     <= cfg_data[CORNER_W-1:0];
				REG_CORNER_B_X:   bx_q     <= cfg_data[CORNER_W-1:0];
				REG_CORNER_B_Y:   by_q     <= cfg_data[CORNER_W-1:0];
				REG_BORDER_THICK: thick_q  <= cfg_data[THICK_W-1:0];
				REG_BORDER_COLOR: bcolor_q <= cfg_data;
				REG_FILL_ENABLE:  fen_q    <= cfg_data[0];
				REG_FILL_COLOR:   fcolor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// settle count: marks the bounds unusable after a write, and after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 2'd2;
		end else if (cfg_wr) begin
			settle_q <= 2'd1;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	assign geom_ok = (settle_q == 2'd0);

	// first precompute stage: corner, side and half bands
	logic signed [CORNER_W:0]   dax, day;
	logic [SIDE_W-1:0]          dx, dy;
	logic [THICK_W-1:0]         thick_m1;
	logic signed [CORNER_W-1:0] cx_q, cy_q;
	logic [SIDE_W-1:0]          s_q;
	logic [HALF_W-1:0]          o_q, i_q;
	logic                       side_en_q;

	always_comb begin
		dax      = {ax_q[CORNER_W-1], ax_q} - {bx_q[CORNER_W-1], bx_q};
		day      = {ay_q[CORNER_W-1], ay_q} - {by_q[CORNER_W-1], by_q};
		dx       = dax[CORNER_W] ? SIDE_W'(-dax) : dax[SIDE_W-1:0];
		dy       = day[CORNER_W] ? SIDE_W'(-day) : day[SIDE_W-1:0];
		thick_m1 = thick_q - THICK_W'(1);
	end

	always_ff @(posedge clk) begin
		cx_q      <= (ax_q < bx_q) ? ax_q : bx_q;
		cy_q      <= (ay_q < by_q) ? ay_q : by_q;
		s_q       <= (dx < dy) ? dx : dy;
		o_q       <= thick_q[THICK_W-1:1];
		i_q       <= (thick_q == '0) ? '0 : thick_m1[THICK_W-1:1];
		side_en_q <= (thick_q != '0);
	end

	// second precompute stage: inclusive bounds per axis
	coord_t cxw, cyw, sw, ow, iw;
	geom_t  geom_d, geom_q;

	always_comb begin
		cxw = {{(COORD_W-CORNER_W){cx_q[CORNER_W-1]}}, cx_q};
		cyw = {{(COORD_W-CORNER_W){cy_q[CORNER_W-1]}}, cy_q};
		sw  = {{(COORD_W-SIDE_W){1'b0}}, s_q};
		ow  = {{(COORD_W-HALF_W){1'b0}}, o_q};
		iw  = {{(COORD_W-HALF_W){1'b0}}, i_q};
		geom_d.x_lo         = cxw - ow;
		geom_d.x_hi         = cxw + sw - coord_t'(1) + ow;
		geom_d.x_in         = cxw + iw;
		geom_d.x_out        = cxw + sw - coord_t'(1) - iw;
		geom_d.fx_lo        = cxw + iw + coord_t'(1);
		geom_d.fx_hi        = cxw + sw - coord_t'(2) - iw;
		geom_d.y_lo         = cyw - ow;
		geom_d.y_hi         = cyw + sw - coord_t'(1) + ow;
		geom_d.y_in         = cyw + iw;
		geom_d.y_out        = cyw + sw - coord_t'(1) - iw;
		geom_d.fy_lo        = cyw + iw + coord_t'(1);
		geom_d.fy_hi        = cyw + sw - coord_t'(2) - iw;
		geom_d.side_en      = side_en_q;
		geom_d.fill_en      = fen_q;
		geom_d.border_color = bcolor_q;
		geom_d.fill_color   = fcolor_q;
	end

	always_ff @(posedge clk) begin
		geom_q <= geom_d;
	end

	assign geom = geom_q;

	// a write always blocks pixels for the next cycle
	a_write_settles: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !geom_ok)
		else $error("bounds marked usable right after a register write");

	// settle count only moves downward without a write
	a_settle_down: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr && settle_q == 2'd0 |=> settle_q == 2'd0)
		else $error("settle count rose without a register write");

	// a write with no write right after it leaves bounds usable once the settle count runs out
	a_settle_done: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr ##1 !cfg_wr |=> geom_ok)
		else $error("bounds still settling two cycles after a write");

endmodule

@@ hw/rtl/sofo_pix.sv @@
// pixel pipeline: input register, region test, result register
module sofo_pix
	import sofo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  geom_t              geom,
	input  logic               geom_ok,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIX_W-1:0]   pixel_x,
	input  logic [PIX_W-1:0]   pixel_y,
	input  logic [COLOR_W-1:0] pixel_color,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] out_color
);

	logic               valid_s1, valid_s2;
	logic [PIX_W-1:0]   px_s1, py_s1;
	logic [COLOR_W-1:0] color_s1, color_s2;
	logic               in_beat, adv2;

	assign adv2     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = (!valid_s1 || adv2) && geom_ok;
	assign in_beat  = in_valid && in_ready;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_beat) begin
				valid_s1 <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_beat) begin
			px_s1    <= pixel_x;
			py_s1    <= pixel_y;
			color_s1 <= pixel_color;
		end
	end

	// region test against the precomputed bounds
	coord_t             pxw, pyw;
	logic               on_img, in_x, in_y, band, side, fill;
	logic [COLOR_W-1:0] color_d;

	always_comb begin
		pxw    = {{(COORD_W-PIX_W){1'b0}}, px_s1};
		pyw    = {{(COORD_W-PIX_W){1'b0}}, py_s1};
		on_img = ({1'b0, px_s1} < (PIX_W+1)'(MAX_DIM)) &&
		         ({1'b0, py_s1} < (PIX_W+1)'(MAX_DIM));
		in_x   = (pxw >= geom.x_lo) && (pxw <= geom.x_hi);
		in_y   = (pyw >= geom.y_lo) && (pyw <= geom.y_hi);
		band   = (pxw <= geom.x_in) || (pxw >= geom.x_out) ||
		         (pyw <= geom.y_in) || (pyw >= geom.y_out);
		side   = geom.side_en && in_x && in_y && band;
		fill   = geom.fill_en &&
		         (pxw >= geom.fx_lo) && (pxw <= geom.fx_hi) &&
		         (pyw >= geom.fy_lo) && (pyw <= geom.fy_hi);
		if (on_img && side) begin
			color_d = geom.border_color;
		end else if (on_img && fill) begin
			color_d = geom.fill_color;
		end else begin
			color_d = color_s1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv2) begin
			color_s2 <= color_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_color = color_s2;

	// an accepted beat always lands in the input stage
	a_beat_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> valid_s1)
		else $error("accepted pixel missing from input stage");

	// a full pipe under stall takes no new pixel
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |-> !in_ready)
		else $error("pixel accepted while both stages are held");

	// no pixel enters while bounds are settling
	a_settle_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!geom_ok |-> !in_ready)
		else $error("pixel accepted against stale bounds");

endmodule

@@ hw/rtl/square_outline_fill_overlay_core.sv @@
// Square outline and fill overlay for a pixel stream.
//
// Channels: a register write port (cfg_valid/cfg_ready, cfg_index, cfg_data),
// a pixel input (in_valid/in_ready with pixel_x, pixel_y, pixel_color) and a
// result output (out_valid/out_ready with out_color). Every input beat yields
// exactly one output beat, in order.
//
// An input beat is captured in the input register, goes through the region
// compares, and is captured in the result register, which drives out_valid and
// out_color. Throughput is one pixel per clock while the bounds are usable;
// the two-entry pipeline keeps taking pixels while a finished result waits,
// and when the receiver stalls with both stages full, in_ready drops until
// the result register drains.
//
// The square bounds are precomputed from the registers in two stages, so a
// register write holds in_ready low for the next cycle. The user must write
// registers only with the pipeline empty; the block does not enforce it. Reset
// restores register defaults (thickness 1, everything else zero), empties the
// pipeline, and keeps in_ready low after release while the bounds settle.
module square_outline_fill_overlay_core
	import sofo_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel_x,
	input  logic [PIX_W-1:0]     pixel_y,
	input  logic [COLOR_W-1:0]   pixel_color,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COLOR_W-1:0]   out_color
);

	geom_t geom;
	logic  geom_ok;

	// registers and bounds precompute
	sofo_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.geom_ok   (geom_ok)
	);

	// per-pixel pipeline
	sofo_pix u_pix (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.geom_ok     (geom_ok),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_color   (out_color)
	);

endmodule
